@@ rtl/afr_pkg.sv @@
// Package for the addressed frame receiver: types, constants and the
// CRC-16/ARC byte update. No dependencies.
package afr_pkg;

	localparam int BUF_DEPTH_DEF = 128;
	localparam int CNT_W         = 8;
	localparam int IDX_W         = 7;
	localparam int FIFO_DEPTH    = 2;

	localparam logic [7:0]  OWN_ADDR_RST = 8'h01;
	localparam logic [15:0] CRC_POLY     = 16'hA001;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DROP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ADDR    = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DATA    = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [7:0]        ch;
		logic              addr_match;
	} cmd_t;

	// front to back: head of the command queue
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_link_t;

	typedef struct packed {
		logic             byte_valid;
		logic [IDX_W-1:0] byte_index;
		logic [7:0]       byte_out;
		logic             frame_end;
		logic             crc_ok;
		logic             broadcast;
		logic             pending;
	} res_t;

	function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/afr_fifo.sv @@
// Small generic queue with registered storage and occupancy count.
// No dependencies.
module afr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/afr_front.sv @@
// Front part: holds the station address, classifies each input beat and
// queues it for the back part. Uses afr_pkg and afr_fifo.
module afr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	input  logic                push,
	output logic                full,
	input  logic                op,
	input  logic [7:0]          char_byte,
	input  logic                ninth_bit,
	input  logic                line_error,
	output afr_pkg::cmd_link_t  link,
	input  logic                link_pop
);

	logic [7:0]    own_addr_q;
	afr_pkg::cmd_t cmd_in, cmd_head;
	logic          q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_addr_q <= afr_pkg::OWN_ADDR_RST;
		end else if (cfg_we) begin
			own_addr_q <= cfg_wdata;
		end
	end

	always_comb begin
		cmd_in.ch         = char_byte;
		cmd_in.addr_match = (char_byte == own_addr_q) || (char_byte == 8'h00);
		if (op) begin
			cmd_in.kind = afr_pkg::KIND_CONSUME;
		end else if (line_error) begin
			cmd_in.kind = afr_pkg::KIND_DROP;
		end else if (ninth_bit) begin
			cmd_in.kind = afr_pkg::KIND_ADDR;
		end else begin
			cmd_in.kind = afr_pkg::KIND_DATA;
		end
	end

	afr_fifo #(
		.WIDTH($bits(afr_pkg::cmd_t)),
		.DEPTH(afr_pkg::FIFO_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (link_pop),
		.rdata (cmd_head),
		.empty (q_empty)
	);

	assign link.valid = !q_empty;
	assign link.cmd   = cmd_head;

endmodule

@@ rtl/afr_back.sv @@
// Back part: frame state, CRC-16/ARC check and the result queue.
// Uses afr_pkg and afr_fifo.
module afr_back #(
	parameter int BUF_DEPTH = afr_pkg::BUF_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  afr_pkg::cmd_link_t link,
	output logic               link_pop,
	output afr_pkg::res_t      res_head,
	output logic               res_empty,
	input  logic               res_pop
);

	localparam int CW = afr_pkg::CNT_W;

	logic          in_frame_q, in_frame_n;
	logic          pending_q, pending_n;
	logic          bcast_q, bcast_n;
	logic [CW-1:0] cnt_q, cnt_n;
	logic [7:0]    len_q, len_n;
	logic [15:0]   crc_q, crc_n;
	logic [7:0]    crc_lo_q, crc_lo_n;
	logic          res_full, step;
	logic [CW:0]   pos_p1, len_p1, len_p3;
	afr_pkg::res_t res;
	afr_pkg::cmd_t cmd;

	assign cmd      = link.cmd;
	assign step     = link.valid && !res_full;
	assign link_pop = step;
	assign pos_p1   = {1'b0, cnt_q} + 1'b1;
	assign len_p1   = {1'b0, len_q} + 1'b1;
	assign len_p3   = {1'b0, len_q} + 2'd3;

	always_comb begin
		in_frame_n = in_frame_q;
		pending_n  = pending_q;
		bcast_n    = bcast_q;
		cnt_n      = cnt_q;
		len_n      = len_q;
		crc_n      = crc_q;
		crc_lo_n   = crc_lo_q;
		res        = '0;
		case (cmd.kind)
			afr_pkg::KIND_CONSUME: begin
				pending_n = 1'b0;
			end
			afr_pkg::KIND_ADDR: begin
				if (!pending_q && cmd.addr_match) begin
					bcast_n    = (cmd.ch == 8'h00);
					in_frame_n = 1'b1;
					cnt_n      = '0;
					crc_n      = afr_pkg::crc16_feed(16'h0000, cmd.ch);
				end
			end
			afr_pkg::KIND_DATA: begin
				if (in_frame_q && (cnt_q < CW'(BUF_DEPTH))) begin
					if (cnt_q == '0) begin
						len_n = cmd.ch;
						crc_n = afr_pkg::crc16_feed(crc_q, cmd.ch);
					end else if (cnt_q <= len_q) begin
						crc_n = afr_pkg::crc16_feed(crc_q, cmd.ch);
					end else if ({1'b0, cnt_q} == len_p1) begin
						crc_lo_n = cmd.ch;
					end
					res.byte_valid = 1'b1;
					res.byte_index = cnt_q[afr_pkg::IDX_W-1:0];
					res.byte_out   = cmd.ch;
					cnt_n          = pos_p1[CW-1:0];
					if (pos_p1 >= len_p3) begin
						res.frame_end = 1'b1;
						res.crc_ok    = ({cmd.ch, crc_lo_q} == crc_q);
						if ({cmd.ch, crc_lo_q} == crc_q) begin
							pending_n = 1'b1;
						end
						in_frame_n = 1'b0;
						crc_n      = '0;
					end
				end
			end
			default: begin
			end
		endcase
		res.broadcast = bcast_n;
		res.pending   = pending_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pending_q  <= 1'b0;
			bcast_q    <= 1'b1;
			cnt_q      <= '0;
			len_q      <= '0;
			crc_q      <= '0;
			crc_lo_q   <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_n;
			pending_q  <= pending_n;
			bcast_q    <= bcast_n;
			cnt_q      <= cnt_n;
			len_q      <= len_n;
			crc_q      <= crc_n;
			crc_lo_q   <= crc_lo_n;
		end
	end

	afr_fifo #(
		.WIDTH($bits(afr_pkg::res_t)),
		.DEPTH(afr_pkg::FIFO_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (step),
		.wdata (res),
		.full  (res_full),
		.pop   (res_pop),
		.rdata (res_head),
		.empty (res_empty)
	);

endmodule

@@ rtl/addressed_frame_receiver_crc16_unit.sv @@
// Nine-bit multidrop frame receiver with CRC-16/ARC check. Takes one beat
// per clock while full is low and returns exactly one result beat per input
// beat through empty/pop, in order. Accepted beats pass the command queue,
// then the result queue; the back part's combinational CRC update takes one
// beat per cycle unless the result queue is full. Two-entry queues between
// the front, the back and the result ports let each side stall independently.
// Top level; uses afr_pkg, afr_front, afr_back.
module addressed_frame_receiver_crc16_unit #(
	parameter int BUF_DEPTH = afr_pkg::BUF_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [7:0]                cfg_wdata,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic [7:0]                char_byte,
	input  logic                      ninth_bit,
	input  logic                      line_error,
	output logic                      empty,
	input  logic                      pop,
	output logic                      byte_valid,
	output logic [afr_pkg::IDX_W-1:0] byte_index,
	output logic [7:0]                byte_out,
	output logic                      frame_end,
	output logic                      crc_ok,
	output logic                      broadcast,
	output logic                      pending
);

	afr_pkg::cmd_link_t link;
	logic               link_pop;
	afr_pkg::res_t      res_head;

	afr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.op        (op),
		.char_byte (char_byte),
		.ninth_bit (ninth_bit),
		.line_error(line_error),
		.link      (link),
		.link_pop  (link_pop)
	);

	afr_back #(
		.BUF_DEPTH(BUF_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.link     (link),
		.link_pop (link_pop),
		.res_head (res_head),
		.res_empty(empty),
		.res_pop  (pop)
	);

	assign byte_valid = res_head.byte_valid;
	assign byte_index = res_head.byte_index;
	assign byte_out   = res_head.byte_out;
	assign frame_end  = res_head.frame_end;
	assign crc_ok     = res_head.crc_ok;
	assign broadcast  = res_head.broadcast;
	assign pending    = res_head.pending;

	a_end_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && frame_end) |-> byte_valid)
		else $error("frame end without a stored byte");

	a_ok_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && crc_ok) |-> (frame_end && pending))
		else $error("crc verdict without frame end or pending");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !byte_valid) |-> (byte_index == '0 && byte_out == 8'h00))
		else $error("byte fields set on a beat with no stored byte");

	a_back_steps_only_with_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		link_pop |-> link.valid)
		else $error("back part consumed from an empty command queue");

endmodule
